[rtl/jtsc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the JSON token syntax checker.
// No dependencies; every other file refers to it by scoped names.
package jtsc_pkg;

  typedef enum logic [3:0] {
    TK_OBJ_OPEN  = 4'd0,
    TK_OBJ_CLOSE = 4'd1,
    TK_ARR_OPEN  = 4'd2,
    TK_ARR_CLOSE = 4'd3,
    TK_COMMA     = 4'd4,
    TK_COLON     = 4'd5,
    TK_STRING    = 4'd6,
    TK_LITERAL   = 4'd7,
    TK_NUMBER    = 4'd8
  } token_e;

  typedef enum logic [2:0] {
    PH_VALUE            = 3'd0,
    PH_VALUE_OR_ARR_END = 3'd1,
    PH_KEY_OR_OBJ_END   = 3'd2,
    PH_KEY              = 3'd3,
    PH_COLON            = 3'd4,
    PH_SEP_OR_END       = 3'd5,
    PH_DONE             = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_SYNTAX   = 2'd2,
    ST_DEEP     = 2'd3
  } status_e;

  // Stack operation requested by the grammar logic for one item.
  typedef struct packed {
    logic push;
    logic pop;
    logic push_obj;
  } stack_op_t;

  localparam int unsigned CfgWidth   = 6;
  localparam int unsigned DepthWidth = 6;

endpackage

[rtl/jtsc_stack.sv]
`timescale 1ns / 1ps
// Container stack: depth counter, registered top entry and a synchronous
// memory for the entries below it. Uses jtsc_pkg for the operation struct.
module jtsc_stack #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             acc_i,
  input  logic                             restart_i,
  input  jtsc_pkg::stack_op_t              op_i,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]   depth_eff_i,
  output logic [$clog2(MAX_DEPTH+1)-1:0]   depth_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0]   depth_next_o,
  output logic                             top_obj_o
);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic          mem_q [MAX_DEPTH];
  logic [DW-1:0] depth_q, depth_d;
  logic          top_q, top_d;
  logic          below_q;
  logic          we;
  logic [DW-1:0] waddr_full, raddr_full;
  logic [AW-1:0] waddr, raddr;

  // Pushing moves the old top into memory; popping takes the prefetched
  // entry below the top, which is always read at the depth of the next cycle.
  always_comb begin
    depth_d = depth_q;
    top_d   = top_q;
    we      = 1'b0;
    if (acc_i) begin
      depth_d = depth_eff_i;
      if (op_i.push) begin
        depth_d = depth_eff_i + DW'(1);
        top_d   = op_i.push_obj;
        we      = (depth_eff_i != '0) && !restart_i;
      end else if (op_i.pop) begin
        depth_d = depth_eff_i - DW'(1);
        top_d   = below_q;
      end
    end
  end

  assign waddr_full = depth_eff_i - DW'(1);
  assign raddr_full = depth_d - DW'(2);
  assign waddr      = waddr_full[AW-1:0];
  assign raddr      = raddr_full[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= top_q;
    end
    if (we && (waddr == raddr)) begin
      below_q <= top_q;
    end else begin
      below_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      top_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      top_q   <= top_d;
    end
  end

  assign depth_o      = depth_q;
  assign depth_next_o = depth_d;
  assign top_obj_o    = top_q;

endmodule

[rtl/jtsc_grammar.sv]
`timescale 1ns / 1ps
// Grammar step: from token, phase, depth, top of stack and error state it
// derives status, next phase, next error and the stack operation (jtsc_pkg).
module jtsc_grammar #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic [3:0]                       token_kind_i,
  input  jtsc_pkg::phase_e                 phase_i,
  input  jtsc_pkg::status_e                err_i,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]   depth_i,
  input  logic                             top_obj_i,
  input  logic [jtsc_pkg::CfgWidth-1:0]    depth_limit_i,
  output jtsc_pkg::status_e                status_o,
  output jtsc_pkg::phase_e                 phase_o,
  output jtsc_pkg::status_e                err_o,
  output jtsc_pkg::stack_op_t              op_o
);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LW = (DW > jtsc_pkg::CfgWidth) ? DW : jtsc_pkg::CfgWidth;

  logic          want_value, want_key, is_obj, deep, last;
  logic [LW-1:0] limit, depth_ext;
  jtsc_pkg::status_e st;
  jtsc_pkg::phase_e  ph;
  jtsc_pkg::stack_op_t op;

  assign depth_ext  = LW'(depth_i);
  assign limit      = (LW'(depth_limit_i) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH)
                                                            : LW'(depth_limit_i);
  assign deep       = depth_ext >= limit;
  assign is_obj     = (depth_i != '0) && top_obj_i;
  assign last       = (depth_i == DW'(1));
  assign want_value = (phase_i == jtsc_pkg::PH_VALUE) ||
                      (phase_i == jtsc_pkg::PH_VALUE_OR_ARR_END);
  assign want_key   = (phase_i == jtsc_pkg::PH_KEY) ||
                      (phase_i == jtsc_pkg::PH_KEY_OR_OBJ_END);

  always_comb begin
    st = jtsc_pkg::ST_OK;
    ph = phase_i;
    op = '0;
    if (err_i != jtsc_pkg::ST_OK) begin
      st = err_i;
    end else begin
      unique case (token_kind_i)
        jtsc_pkg::TK_OBJ_OPEN, jtsc_pkg::TK_ARR_OPEN: begin
          if (!want_value) begin
            st = jtsc_pkg::ST_SYNTAX;
          end else if (deep) begin
            st = jtsc_pkg::ST_DEEP;
          end else begin
            op.push     = 1'b1;
            op.push_obj = (token_kind_i == jtsc_pkg::TK_OBJ_OPEN);
            ph = op.push_obj ? jtsc_pkg::PH_KEY_OR_OBJ_END : jtsc_pkg::PH_VALUE_OR_ARR_END;
          end
        end
        jtsc_pkg::TK_OBJ_CLOSE, jtsc_pkg::TK_ARR_CLOSE: begin
          if (token_kind_i == jtsc_pkg::TK_OBJ_CLOSE ?
              (!is_obj || (phase_i != jtsc_pkg::PH_KEY_OR_OBJ_END &&
                           phase_i != jtsc_pkg::PH_SEP_OR_END)) :
              (depth_i == '0 || is_obj ||
               (phase_i != jtsc_pkg::PH_VALUE_OR_ARR_END &&
                phase_i != jtsc_pkg::PH_SEP_OR_END))) begin
            st = jtsc_pkg::ST_SYNTAX;
          end else begin
            op.pop = 1'b1;
            st = last ? jtsc_pkg::ST_COMPLETE : jtsc_pkg::ST_OK;
            ph = last ? jtsc_pkg::PH_DONE : jtsc_pkg::PH_SEP_OR_END;
          end
        end
        jtsc_pkg::TK_COMMA: begin
          if (phase_i != jtsc_pkg::PH_SEP_OR_END || depth_i == '0) begin
            st = jtsc_pkg::ST_SYNTAX;
          end else begin
            ph = is_obj ? jtsc_pkg::PH_KEY : jtsc_pkg::PH_VALUE;
          end
        end
        jtsc_pkg::TK_COLON: begin
          if (phase_i != jtsc_pkg::PH_COLON) begin
            st = jtsc_pkg::ST_SYNTAX;
          end else begin
            ph = jtsc_pkg::PH_VALUE;
          end
        end
        jtsc_pkg::TK_STRING, jtsc_pkg::TK_LITERAL, jtsc_pkg::TK_NUMBER: begin
          if (want_key && token_kind_i == jtsc_pkg::TK_STRING) begin
            ph = jtsc_pkg::PH_COLON;
          end else if (!want_value) begin
            st = jtsc_pkg::ST_SYNTAX;
          end else if (depth_i == '0) begin
            st = jtsc_pkg::ST_COMPLETE;
            ph = jtsc_pkg::PH_DONE;
          end else begin
            ph = jtsc_pkg::PH_SEP_OR_END;
          end
        end
        default: begin
          st = jtsc_pkg::ST_SYNTAX;
        end
      endcase
    end
  end

  assign status_o = st;
  assign phase_o  = ph;
  assign op_o     = op;
  assign err_o    = (st == jtsc_pkg::ST_SYNTAX || st == jtsc_pkg::ST_DEEP) ? st
                                                                           : jtsc_pkg::ST_OK;

endmodule

[rtl/json_token_syntax_checker.sv]
`timescale 1ns / 1ps
// JSON token syntax checker, top level. Latency: the result of an item is
// valid in the cycle after the item is accepted. Throughput: one item per
// cycle unless out_ready_i holds the result, set by the read-modify-write of the container stack.
// Reset is asynchronous active low; it empties the stack, sets the phase to
// expect a value, clears the error and sets depth_limit to 32. No clear pass.
module json_token_syntax_checker #(
  parameter int unsigned MAX_DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jtsc_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [3:0]                       token_kind_i,
  input  logic                             restart_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [jtsc_pkg::DepthWidth-1:0]  nesting_depth_o
);
  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned LW = (DW > jtsc_pkg::DepthWidth) ? DW : jtsc_pkg::DepthWidth;

  logic [jtsc_pkg::CfgWidth-1:0] limit_q;
  jtsc_pkg::phase_e    phase_q, phase_d, phase_eff, phase_new;
  jtsc_pkg::status_e   err_q, err_d, err_eff, err_new, status;
  jtsc_pkg::stack_op_t op;
  logic [DW-1:0]       depth, depth_eff, depth_next;
  logic [LW-1:0]       depth_next_ext;
  logic                top_obj, acc;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [jtsc_pkg::DepthWidth-1:0] out_depth_q;

  // The output register separates the two sides: a new item is taken
  // whenever the held result is empty or is being taken in this cycle.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // A restart clears stack depth, phase and error ahead of the token itself.
  assign depth_eff = restart_i ? '0 : depth;
  assign phase_eff = restart_i ? jtsc_pkg::PH_VALUE : phase_q;
  assign err_eff   = restart_i ? jtsc_pkg::ST_OK : err_q;

  jtsc_grammar #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_grammar (
    .token_kind_i (token_kind_i),
    .phase_i      (phase_eff),
    .err_i        (err_eff),
    .depth_i      (depth_eff),
    .top_obj_i    (top_obj),
    .depth_limit_i(limit_q),
    .status_o     (status),
    .phase_o      (phase_new),
    .err_o        (err_new),
    .op_o         (op)
  );

  // The stack holds its top entry in a register and the rest in memory; the
  // entry below the top is prefetched every cycle so a pop needs no wait.
  jtsc_stack #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .restart_i   (restart_i),
    .op_i        (op),
    .depth_eff_i (depth_eff),
    .depth_o     (depth),
    .depth_next_o(depth_next),
    .top_obj_o   (top_obj)
  );

  assign phase_d        = acc ? phase_new : phase_q;
  assign err_d          = acc ? err_new : err_q;
  assign depth_next_ext = LW'(depth_next);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= jtsc_pkg::PH_VALUE;
      err_q       <= jtsc_pkg::ST_OK;
      limit_q     <= jtsc_pkg::CfgWidth'(32);
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      err_q   <= err_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q    <= status;
      out_depth_q <= depth_next_ext[jtsc_pkg::DepthWidth-1:0];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign nesting_depth_o = out_depth_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the JSON token syntax checker.
// Depends on jtsc_pkg and json_token_syntax_checker; predicts every result in-line.
module tb_top;

  // Nesting limit built into the block under test.
  localparam int unsigned NEST_MAX = 32;
  // Token codes above the last defined kind are all treated as garbage.
  localparam logic [3:0] TK_UNKNOWN_TOP = 4'hF;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HANG_LIMIT = 2000;

  // Expected answer for one token item.
  typedef struct packed {
    jtsc_pkg::status_e status;
    logic [5:0]        depth;
  } verdict_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [jtsc_pkg::CfgWidth-1:0]   cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic [3:0]                      token_kind_i;
  logic                            restart_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic [1:0]                      status_o;
  logic [jtsc_pkg::DepthWidth-1:0] nesting_depth_o;

  // Grammar state mirrored by the testbench. Only entries below nest_level
  // are ever read, so the container-kind array needs no reset.
  logic              nest_is_obj [NEST_MAX];
  int unsigned       nest_level;
  jtsc_pkg::phase_e  grammar_phase;
  jtsc_pkg::status_e sticky_err;
  logic [5:0]        depth_cap;

  verdict_t    pending_verdicts[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned stall_left;

  // Stimulus shaping knobs, changed per test phase.
  bit          no_gaps;
  int unsigned dive_pct;
  int unsigned noise_pct;

  json_token_syntax_checker #(
    .MAX_DEPTH(NEST_MAX)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .token_kind_i   (token_kind_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .nesting_depth_o(nesting_depth_o)
  );

  // 4 ns clock period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Idle length used by both the sender and the result receiver: mostly no
  // gap, often a short one and now and then a long one.
  function automatic int unsigned gap_draw();
    int unsigned roll;
    roll = $urandom_range(99);
    if (no_gaps || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(3, 1);
    end else if (roll < 98) begin
      return $urandom_range(12, 4);
    end
    return $urandom_range(40, 20);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // A value has just ended. At the top level that finishes the document;
  // inside a container the grammar now wants a separator or a close.
  function automatic jtsc_pkg::status_e value_closed();
    if (nest_level == 0) begin
      grammar_phase = jtsc_pkg::PH_DONE;
      return jtsc_pkg::ST_COMPLETE;
    end
    grammar_phase = jtsc_pkg::PH_SEP_OR_END;
    return jtsc_pkg::ST_OK;
  endfunction

  // Advances the mirrored grammar state by one token item and returns the
  // status and depth that the block must answer with.
  function automatic verdict_t step_grammar(logic [3:0] kind, logic restart);
    verdict_t          v;
    jtsc_pkg::status_e st;
    logic              want_value;
    logic              want_key;
    logic              top_obj;
    int unsigned       cap;
    if (restart) begin
      nest_level    = 0;
      grammar_phase = jtsc_pkg::PH_VALUE;
      sticky_err    = jtsc_pkg::ST_OK;
    end
    want_value = (grammar_phase == jtsc_pkg::PH_VALUE) ||
                 (grammar_phase == jtsc_pkg::PH_VALUE_OR_ARR_END);
    want_key   = (grammar_phase == jtsc_pkg::PH_KEY) ||
                 (grammar_phase == jtsc_pkg::PH_KEY_OR_OBJ_END);
    top_obj    = (nest_level != 0) && nest_is_obj[nest_level-1];
    // Limits above the built-in stack size saturate; a limit of zero makes
    // every opening bracket where a value is wanted too deep.
    cap = (depth_cap > NEST_MAX) ? NEST_MAX : depth_cap;
    st  = jtsc_pkg::ST_SYNTAX;
    if (sticky_err != jtsc_pkg::ST_OK) begin
      // A latched error answers every item until the next restart.
      st = sticky_err;
    end else begin
      case (kind)
        jtsc_pkg::TK_OBJ_OPEN, jtsc_pkg::TK_ARR_OPEN: begin
          if (want_value && nest_level >= cap) begin
            st = jtsc_pkg::ST_DEEP;
          end else if (want_value) begin
            nest_is_obj[nest_level] = (kind == jtsc_pkg::TK_OBJ_OPEN);
            nest_level++;
            if (kind == jtsc_pkg::TK_OBJ_OPEN) begin
              grammar_phase = jtsc_pkg::PH_KEY_OR_OBJ_END;
            end else begin
              grammar_phase = jtsc_pkg::PH_VALUE_OR_ARR_END;
            end
            st = jtsc_pkg::ST_OK;
          end
        end
        jtsc_pkg::TK_OBJ_CLOSE: begin
          if (top_obj && (grammar_phase == jtsc_pkg::PH_KEY_OR_OBJ_END ||
                          grammar_phase == jtsc_pkg::PH_SEP_OR_END)) begin
            nest_level--;
            st = value_closed();
          end
        end
        jtsc_pkg::TK_ARR_CLOSE: begin
          if (nest_level != 0 && !top_obj &&
              (grammar_phase == jtsc_pkg::PH_VALUE_OR_ARR_END ||
               grammar_phase == jtsc_pkg::PH_SEP_OR_END)) begin
            nest_level--;
            st = value_closed();
          end
        end
        jtsc_pkg::TK_COMMA: begin
          if (grammar_phase == jtsc_pkg::PH_SEP_OR_END && nest_level != 0) begin
            if (top_obj) begin
              grammar_phase = jtsc_pkg::PH_KEY;
            end else begin
              grammar_phase = jtsc_pkg::PH_VALUE;
            end
            st = jtsc_pkg::ST_OK;
          end
        end
        jtsc_pkg::TK_COLON: begin
          if (grammar_phase == jtsc_pkg::PH_COLON) begin
            grammar_phase = jtsc_pkg::PH_VALUE;
            st = jtsc_pkg::ST_OK;
          end
        end
        jtsc_pkg::TK_STRING: begin
          // A string is a key where a key is wanted, otherwise a value.
          if (want_key) begin
            grammar_phase = jtsc_pkg::PH_COLON;
            st = jtsc_pkg::ST_OK;
          end else if (want_value) begin
            st = value_closed();
          end
        end
        jtsc_pkg::TK_LITERAL, jtsc_pkg::TK_NUMBER: begin
          if (want_value) begin
            st = value_closed();
          end
        end
        default: begin
          // Unknown token kinds stay a syntax error.
        end
      endcase
      // A rejected token leaves stack and phase alone but latches the error.
      if (st == jtsc_pkg::ST_SYNTAX || st == jtsc_pkg::ST_DEEP) begin
        sticky_err = st;
      end
    end
    v.status = st;
    v.depth  = nest_level[5:0];
    return v;
  endfunction

  // Drives one token item, waits for its handshake and records the answer
  // that the block owes for it. Valid is left high so that a following item
  // without a gap keeps it high without a glitch.
  task automatic send_token(logic [3:0] kind, logic restart);
    int unsigned gap;
    gap = gap_draw();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    token_kind_i <= kind;
    restart_i    <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    pending_verdicts.push_back(step_grammar(kind, restart));
  endtask

  // Stops sending and waits until every owed result has come back, plus a short pause.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // The depth limit is only changed while the block has nothing in flight.
  task automatic write_depth_cap(logic [5:0] cap);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    depth_cap = cap;
  endtask

  // Picks a token that may start a value: a container with the current dive
  // probability, otherwise one of the scalar kinds.
  function automatic logic [3:0] value_token();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < dive_pct) begin
      return ($urandom_range(1) != 0) ? jtsc_pkg::TK_OBJ_OPEN : jtsc_pkg::TK_ARR_OPEN;
    end
    case ($urandom_range(2))
      0:       return jtsc_pkg::TK_STRING;
      1:       return jtsc_pkg::TK_LITERAL;
      default: return jtsc_pkg::TK_NUMBER;
    endcase
  endfunction

  // Random token generator guided by the mirrored grammar state: mostly the
  // next legal token, with a small share of garbage and stray restarts.
  task automatic choose_token(output logic [3:0] kind, output logic restart);
    int unsigned roll;
    logic        top_obj;
    roll    = $urandom_range(99);
    top_obj = (nest_level != 0) && nest_is_obj[nest_level-1];
    restart = 1'b0;
    if (roll < noise_pct) begin
      kind    = 4'($urandom_range(15));
      restart = ($urandom_range(24) == 0);
    end else if (sticky_err != jtsc_pkg::ST_OK || grammar_phase == jtsc_pkg::PH_DONE) begin
      // Usually start a new document; sometimes keep going to exercise the
      // sticky error and the token after a finished document.
      restart = (roll < 90);
      kind    = value_token();
    end else begin
      case (grammar_phase)
        jtsc_pkg::PH_VALUE: kind = value_token();
        jtsc_pkg::PH_VALUE_OR_ARR_END: begin
          kind = (roll < 20) ? jtsc_pkg::TK_ARR_CLOSE : value_token();
        end
        jtsc_pkg::PH_KEY_OR_OBJ_END: begin
          kind = (roll < 20) ? jtsc_pkg::TK_OBJ_CLOSE : jtsc_pkg::TK_STRING;
        end
        jtsc_pkg::PH_KEY:   kind = jtsc_pkg::TK_STRING;
        jtsc_pkg::PH_COLON: kind = jtsc_pkg::TK_COLON;
        default: begin
          if ($urandom_range(99) < dive_pct) begin
            kind = jtsc_pkg::TK_COMMA;
          end else begin
            kind = top_obj ? jtsc_pkg::TK_OBJ_CLOSE : jtsc_pkg::TK_ARR_CLOSE;
          end
        end
      endcase
    end
  endtask

  // Hand-written documents at the reset depth limit: empty containers, a
  // nested document using every token kind, the sticky error, a token after
  // a finished document, an unknown kind and a stray close at top level.
  task automatic test_grammar_basics();
    send_token(jtsc_pkg::TK_OBJ_OPEN, 1'b0);
    send_token(jtsc_pkg::TK_OBJ_CLOSE, 1'b0);
    send_token(jtsc_pkg::TK_ARR_OPEN, 1'b1);
    send_token(jtsc_pkg::TK_ARR_CLOSE, 1'b0);
    send_token(jtsc_pkg::TK_OBJ_OPEN, 1'b1);
    send_token(jtsc_pkg::TK_STRING, 1'b0);
    send_token(jtsc_pkg::TK_COLON, 1'b0);
    send_token(jtsc_pkg::TK_ARR_OPEN, 1'b0);
    send_token(jtsc_pkg::TK_NUMBER, 1'b0);
    send_token(jtsc_pkg::TK_COMMA, 1'b0);
    send_token(jtsc_pkg::TK_LITERAL, 1'b0);
    send_token(jtsc_pkg::TK_ARR_CLOSE, 1'b0);
    send_token(jtsc_pkg::TK_COMMA, 1'b0);
    send_token(jtsc_pkg::TK_STRING, 1'b0);
    send_token(jtsc_pkg::TK_COLON, 1'b0);
    send_token(jtsc_pkg::TK_STRING, 1'b0);
    send_token(jtsc_pkg::TK_OBJ_CLOSE, 1'b0);
    send_token(jtsc_pkg::TK_COMMA, 1'b0);
    send_token(jtsc_pkg::TK_STRING, 1'b0);
    send_token(TK_UNKNOWN_TOP, 1'b1);
    send_token(jtsc_pkg::TK_ARR_CLOSE, 1'b1);
    send_token(jtsc_pkg::TK_NUMBER, 1'b1);
  endtask

  // Depth limit extremes: one level only, then no level at all.
  task automatic test_depth_extremes();
    write_depth_cap(6'd1);
    send_token(jtsc_pkg::TK_ARR_OPEN, 1'b1);
    send_token(jtsc_pkg::TK_OBJ_OPEN, 1'b0);
    send_token(jtsc_pkg::TK_ARR_CLOSE, 1'b0);
    write_depth_cap(6'd0);
    send_token(jtsc_pkg::TK_OBJ_OPEN, 1'b1);
    send_token(jtsc_pkg::TK_NUMBER, 1'b1);
  endtask

  // Random documents under a series of depth limits. Deep-diving phases keep
  // garbage rare so that the stack can fill up to the limit.
  task automatic test_random_documents();
    logic [5:0]  caps [8];
    int unsigned lens [8];
    logic [3:0]  kind;
    logic        restart;
    int unsigned counted;
    caps = '{6'd63, 6'd32, 6'd2, 6'd33, 6'd1, 6'd0, 6'd17, 6'd32};
    lens = '{150, 150, 110, 110, 80, 40, 150, 110};
    caps[6] = 6'($urandom_range(31, 3));
    foreach (caps[p]) begin
      write_depth_cap(caps[p]);
      no_gaps   = (p == 1) || (p == 7);
      dive_pct  = (caps[p] >= 17) ? 85 : 50;
      noise_pct = (caps[p] >= 17) ? 1 : 6;
      counted   = 0;
      while (counted < lens[p]) begin
        choose_token(kind, restart);
        // Items swallowed by a latched error do not count.
        if (sticky_err == jtsc_pkg::ST_OK || restart) begin
          counted++;
        end
        send_token(kind, restart);
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result receiver: random stalls, with a hold counter for the long ones.
  always @(posedge clk_i) begin
    if (no_gaps) begin
      out_ready_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      stall_left = gap_draw();
      if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted result item is compared with the oldest owed answer.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result item with nothing owed, status", int'(status_o), -1);
      end else begin
        want = pending_verdicts.pop_front();
        if (status_o !== want.status) begin
          report_mismatch("status", int'(status_o), int'(want.status));
        end
        if (nesting_depth_o !== want.depth) begin
          report_mismatch("nesting depth", int'(nesting_depth_o), int'(want.depth));
        end
      end
    end
  end

  // Hang detection: any handshake on any channel resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    token_kind_i <= '0;
    restart_i    <= 1'b0;
    out_ready_i  <= 1'b0;
    idle_cycles  = 0;
    stall_left   = 0;
    mismatch_count = 0;
    no_gaps      = 1'b0;
    dive_pct     = 50;
    noise_pct    = 6;
    // Mirror of the reset state: empty stack, expecting a value, no error.
    nest_level    = 0;
    grammar_phase = jtsc_pkg::PH_VALUE;
    sticky_err    = jtsc_pkg::ST_OK;
    depth_cap     = 6'd32;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_grammar_basics();
    test_depth_extremes();
    test_random_documents();

    drain_results();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
